@@ rtl/fbpa_pkg.sv @@
// fbpa_pkg: shared types for the fixed block pool allocator
// result status codes and the controller to datapath command and status groups
// no dependencies
`default_nettype none

package fbpa_pkg;

	typedef enum logic [2:0] {
		ST_ALLOC = 3'd0,
		ST_EMPTY = 3'd1,
		ST_FREED = 3'd2,
		ST_NULL  = 3'd3,
		ST_BAD   = 3'd4
	} status_t;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_t;

	// controller to datapath
	typedef struct packed {
		logic init_wr;
		logic accept;
		logic commit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic init_last;
		logic is_alloc;
	} dp_sts_t;

endpackage

`default_nettype wire

@@ rtl/fbpa_ram.sv @@
// fbpa_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module fbpa_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/fbpa_ctrl.sv @@
// fbpa_ctrl: sequencing state machine and output handshake of the allocator
// depends on fbpa_pkg for the command and status groups
`default_nettype none

module fbpa_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output fbpa_pkg::dp_cmd_t      cmd,
	input  wire fbpa_pkg::dp_sts_t sts
);
	import fbpa_pkg::*;

	typedef enum logic [3:0] {
		S_INIT = 4'b0001,
		S_IDLE = 4'b0010,
		S_CALC = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d     = state_q;
		cmd.init_wr = 1'b0;
		cmd.accept  = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			S_INIT: begin
				cmd.init_wr = 1'b1;
				if (sts.init_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_CALC;
				end
			end
			S_CALC: begin
				if (!sts.is_alloc) begin
					state_d = S_FIN;
				end else if (slot_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_FIN: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/fbpa_dpath.sv @@
// fbpa_dpath: free list memory, head and count registers, address checks and results
// depends on fbpa_pkg and fbpa_ram
`default_nettype none

module fbpa_dpath #(
	parameter int BLOCK_COUNT = 8,
	parameter int BLOCK_BYTES = 32,
	parameter int ADDR_BITS   = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire fbpa_pkg::dp_cmd_t                  cmd,
	output fbpa_pkg::dp_sts_t                       sts,
	input  wire logic                               cfg_wr_en,
	input  wire logic [ADDR_BITS-1:0]               cfg_wr_data,
	input  wire logic                               req_type,
	input  wire logic [ADDR_BITS-1:0]               free_addr,
	output logic      [2:0]                         status,
	output logic      [ADDR_BITS-1:0]               block_addr,
	output logic      [$clog2(BLOCK_COUNT+1)-1:0]   used_count,
	output logic      [$clog2(BLOCK_COUNT+1)-1:0]   peak_count
);
	import fbpa_pkg::*;

	localparam int CNT_W = $clog2(BLOCK_COUNT + 1);
	localparam int AW    = $clog2(BLOCK_COUNT);
	localparam int OFF_W = $clog2(BLOCK_COUNT * BLOCK_BYTES);
	localparam int EXT_W = (ADDR_BITS > OFF_W) ? ADDR_BITS : OFF_W;
	localparam int BW    = $clog2(BLOCK_BYTES);
	localparam int SH    = OFF_W + BW;
	localparam int RW    = OFF_W + 1;
	localparam int PW    = OFF_W + RW;
	localparam longint unsigned RECIP_L =
		((64'd1 << SH) + BLOCK_BYTES - 1) / BLOCK_BYTES;
	localparam logic [RW-1:0]    RECIP = RW'(RECIP_L);
	localparam logic [EXT_W-1:0] LIMIT = EXT_W'(BLOCK_COUNT * BLOCK_BYTES);
	localparam logic [CNT_W-1:0] FULL  = CNT_W'(BLOCK_COUNT);

	logic [ADDR_BITS-1:0] pool_base_q;
	logic [CNT_W-1:0]     head_q;
	logic [CNT_W-1:0]     used_q;
	logic [CNT_W-1:0]     peak_q;
	logic [AW-1:0]        init_cnt_q;

	req_t                 req_q;
	logic                 null_q;
	logic                 empty_q;
	logic                 in_range_q;
	logic [OFF_W-1:0]     off_lo_q;
	logic [OFF_W-1:0]     bofs_q;
	logic [PW-1:0]        prod_q;

	status_t              status_q;
	logic [ADDR_BITS-1:0] block_addr_q;

	logic [ADDR_BITS-1:0] off;
	logic [EXT_W-1:0]     off_ext;
	logic [CNT_W-1:0]     q_blk;
	logic                 aligned;
	logic                 free_ok;
	logic [CNT_W-1:0]     used_inc;
	logic [ADDR_BITS-1:0] alloc_addr;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [CNT_W-1:0]     ram_wdata;
	logic                 ram_re;
	logic [CNT_W-1:0]     ram_rdata;

	assign off     = free_addr - pool_base_q;
	assign off_ext = EXT_W'(off);

	assign q_blk   = CNT_W'(prod_q >> SH);
	assign aligned = (OFF_W'(q_blk * BLOCK_BYTES) == off_lo_q);
	assign free_ok = !null_q && in_range_q && aligned;

	assign used_inc   = (used_q < FULL) ? used_q + CNT_W'(1) : used_q;
	assign alloc_addr = pool_base_q + ADDR_BITS'(EXT_W'(bofs_q));

	assign ram_re    = cmd.accept && !(head_q >= FULL);
	assign ram_we    = cmd.init_wr || (cmd.commit && (req_q == REQ_FREE) && free_ok);
	assign ram_waddr = cmd.init_wr ? init_cnt_q : q_blk[AW-1:0];
	assign ram_wdata = cmd.init_wr ? CNT_W'(init_cnt_q) + CNT_W'(1) : head_q;

	fbpa_ram #(
		.WIDTH (CNT_W),
		.DEPTH (BLOCK_COUNT)
	) u_free_list (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (head_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	assign sts.init_last = (init_cnt_q == AW'(BLOCK_COUNT - 1));
	assign sts.is_alloc  = (req_q == REQ_ALLOC);

	assign status     = status_q;
	assign block_addr = block_addr_q;
	assign used_count = used_q;
	assign peak_count = peak_q;

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q <= '0;
			head_q      <= '0;
			used_q      <= '0;
			peak_q      <= '0;
			init_cnt_q  <= '0;
		end else begin
			if (cfg_wr_en) begin
				pool_base_q <= cfg_wr_data;
			end
			if (cmd.init_wr) begin
				init_cnt_q <= init_cnt_q + AW'(1);
			end
			if (cmd.commit) begin
				if (req_q == REQ_ALLOC) begin
					if (!empty_q) begin
						head_q <= ram_rdata;
						used_q <= used_inc;
						if (used_inc > peak_q) begin
							peak_q <= used_inc;
						end
					end
				end else if (free_ok) begin
					head_q <= q_blk;
					if (used_q != '0) begin
						used_q <= used_q - CNT_W'(1);
					end
				end
			end
		end
	end

	// request capture, offset split and result payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q      <= req_t'(req_type);
			null_q     <= (free_addr == '0);
			empty_q    <= (head_q >= FULL);
			in_range_q <= (off_ext < LIMIT);
			off_lo_q   <= off_ext[OFF_W-1:0];
			bofs_q     <= OFF_W'(head_q * BLOCK_BYTES);
		end
		prod_q <= PW'(off_lo_q) * PW'(RECIP);
		if (cmd.commit) begin
			if (req_q == REQ_ALLOC) begin
				if (empty_q) begin
					status_q     <= ST_EMPTY;
					block_addr_q <= '0;
				end else begin
					status_q     <= ST_ALLOC;
					block_addr_q <= alloc_addr;
				end
			end else begin
				block_addr_q <= '0;
				if (null_q) begin
					status_q <= ST_NULL;
				end else if (free_ok) begin
					status_q <= ST_FREED;
				end else begin
					status_q <= ST_BAD;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/fixed_block_pool_allocator_top.sv @@
// fixed_block_pool_allocator_top: pool of equal sized blocks kept on a lifo free list
// requests come in on a valid/ready channel, one result leaves per request on
// a second valid/ready channel. pool_base is written through cfg_wr_en/cfg_wr_data.
// req_type 0 allocates and returns the block address, 1 frees free_addr.
// after reset each free list entry is initialised, one entry per cycle, with in_ready
// low until the last is written; configuration writes are taken meanwhile.
// an allocate reads the head's next index from the free list ram at the transfer;
// that registered read data becomes the new head when the result is registered.
// a free registers in turn the offset subtract, the reciprocal multiply, then the
// alignment check and list push.
// one request is in work at a time; the next is taken once the result is
// registered, so a result can wait on out_ready while the next request is transferred.
// a finished request holds in its last state while out_ready is low and the output
// register still holds an untaken result, until that result is taken.
// depends on fbpa_pkg, fbpa_ctrl, fbpa_dpath, fbpa_ram
`default_nettype none

module fixed_block_pool_allocator_top #(
	parameter int BLOCK_COUNT = 8,
	parameter int BLOCK_BYTES = 32,
	parameter int ADDR_BITS   = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [ADDR_BITS-1:0]             cfg_wr_data,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             req_type,
	input  wire logic [ADDR_BITS-1:0]             free_addr,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic      [2:0]                       status,
	output logic      [ADDR_BITS-1:0]             block_addr,
	output logic      [$clog2(BLOCK_COUNT+1)-1:0] used_count,
	output logic      [$clog2(BLOCK_COUNT+1)-1:0] peak_count
);
	import fbpa_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	fbpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	fbpa_dpath #(
		.BLOCK_COUNT (BLOCK_COUNT),
		.BLOCK_BYTES (BLOCK_BYTES),
		.ADDR_BITS   (ADDR_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req_type    (req_type),
		.free_addr   (free_addr),
		.status      (status),
		.block_addr  (block_addr),
		.used_count  (used_count),
		.peak_count  (peak_count)
	);

endmodule

`default_nettype wire

@@ dv/fixed_block_pool_allocator_top_tb.sv @@
// fixed_block_pool_allocator_top_tb: self-checking bench for the block pool allocator
// a table of directed requests, then random alloc/free traffic across several pool_base
// settings and gap patterns, each result checked against a fixed table entry or a behavioural free-list model
// depends on fbpa_pkg and fixed_block_pool_allocator_top
`timescale 1ns / 1ps

module fixed_block_pool_allocator_top_tb;
	import fbpa_pkg::*;

	localparam int BLOCKS      = 8;
	localparam int BLOCK_BYTES = 32;
	localparam int STALL_LIMIT = 5000;
	localparam int LATE_ROW    = 18;
	localparam int ROW_COUNT   = 24;

	typedef struct packed {
		status_t     st;
		logic [31:0] addr;
		logic [3:0]  used;
		logic [3:0]  peak;
	} pool_result_t;

	typedef struct packed {
		req_t         kind;
		logic [31:0]  addr;
		logic         typed;
		pool_result_t res;
	} pool_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        req_type = 1'b0;
	logic [31:0] free_addr = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [31:0] block_addr;
	logic [3:0]  used_count;
	logic [3:0]  peak_count;

	// free list model
	logic [31:0] pool_base_q = '0;
	int          link_next [BLOCKS];
	int          list_head;
	int          blocks_used;
	int          blocks_peak;

	pool_result_t pending_results [$];
	int           live_blocks [$];
	pool_result_t want;
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;
	int           mismatches = 0;
	int           requests_sent = 0;
	int           base_writes = 0;
	int           status_tally [5];
	int           quiet_cycles = 0;

	// late rows exercise the double free and leave the list looped
	pool_row_t rows [ROW_COUNT] = '{
		'{REQ_ALLOC, 32'hFFFF_FFFF, 1'b1, '{ST_ALLOC, 32'h0, 4'd1, 4'd1}},
		'{REQ_FREE,  32'h0000_0000, 1'b1, '{ST_NULL,  32'h0, 4'd1, 4'd1}},
		'{REQ_FREE,  32'hFFFF_FFFF, 1'b1, '{ST_BAD,   32'h0, 4'd1, 4'd1}},
		'{REQ_FREE,  32'h0000_0021, 1'b1, '{ST_BAD,   32'h0, 4'd1, 4'd1}},
		'{REQ_FREE,  32'h0000_0100, 1'b1, '{ST_BAD,   32'h0, 4'd1, 4'd1}},
		'{REQ_ALLOC, 32'h5555_5555, 1'b0, '0},
		'{REQ_ALLOC, 32'hAAAA_AAAA, 1'b0, '0},
		'{REQ_ALLOC, 32'h0000_0000, 1'b0, '0},
		'{REQ_ALLOC, 32'h0000_0000, 1'b0, '0},
		'{REQ_ALLOC, 32'h0000_0000, 1'b0, '0},
		'{REQ_ALLOC, 32'h0000_0000, 1'b0, '0},
		'{REQ_ALLOC, 32'h0000_0000, 1'b0, '0},
		'{REQ_ALLOC, 32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0, 4'd8, 4'd8}},
		'{REQ_FREE,  32'h0000_00E0, 1'b1, '{ST_FREED, 32'h0, 4'd7, 4'd8}},
		'{REQ_FREE,  32'h0000_0020, 1'b0, '0},
		'{REQ_ALLOC, 32'h0000_0000, 1'b0, '0},
		'{REQ_ALLOC, 32'h0000_0000, 1'b0, '0},
		'{REQ_FREE,  32'h0000_00FC, 1'b0, '0},
		'{REQ_FREE,  32'h0000_0040, 1'b0, '0},
		'{REQ_FREE,  32'h0000_0040, 1'b0, '0},
		'{REQ_ALLOC, 32'h0000_0000, 1'b0, '0},
		'{REQ_ALLOC, 32'h0000_0000, 1'b0, '0},
		'{REQ_FREE,  32'h0000_00E0, 1'b0, '0},
		'{REQ_ALLOC, 32'h0000_0000, 1'b0, '0}
	};

	fixed_block_pool_allocator_top #(
		.BLOCK_COUNT (BLOCKS),
		.BLOCK_BYTES (BLOCK_BYTES),
		.ADDR_BITS   (32)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.free_addr   (free_addr),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.block_addr  (block_addr),
		.used_count  (used_count),
		.peak_count  (peak_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic pool_result_t predict_pool(req_t kind, logic [31:0] addr);
		pool_result_t r;
		logic [31:0]  off;
		int           blk;
		r = '0;
		r.st = ST_ALLOC;
		if (kind == REQ_ALLOC) begin
			if (list_head >= BLOCKS) begin
				r.st = ST_EMPTY;
			end else begin
				blk = list_head;
				list_head = link_next[blk];
				if (blocks_used < BLOCKS)
					blocks_used++;
				if (blocks_used > blocks_peak)
					blocks_peak = blocks_used;
				r.addr = pool_base_q + blk * BLOCK_BYTES;
			end
		end else if (addr == '0) begin
			r.st = ST_NULL;
		end else begin
			off = addr - pool_base_q;
			if (off >= BLOCKS * BLOCK_BYTES || off % BLOCK_BYTES != 0) begin
				r.st = ST_BAD;
			end else begin
				blk = off / BLOCK_BYTES;
				link_next[blk] = list_head;
				list_head = blk;
				if (blocks_used > 0)
					blocks_used--;
				r.st = ST_FREED;
			end
		end
		r.used = 4'(blocks_used);
		r.peak = 4'(blocks_peak);
		return r;
	endfunction

	task automatic issue_request(input req_t kind, input logic [31:0] addr, input logic typed,
			input pool_result_t fixed_res);
		pool_result_t r;
		logic [31:0]  off;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		free_addr <= addr;
		do @(posedge clk); while (!in_ready);
		r = predict_pool(kind, addr);
		if (r.st == ST_ALLOC) begin
			off = r.addr - pool_base_q;
			live_blocks.push_back(off / BLOCK_BYTES);
		end
		pending_results.push_back(typed ? fixed_res : r);
		requests_sent++;
	endtask

	task automatic walk_rows(input int first, input int last);
		for (int i = first; i < last; i++)
			issue_request(rows[i].kind, rows[i].addr, rows[i].typed, rows[i].res);
	endtask

	// wild frees pick any block, so double frees and frees at zero use occur
	task automatic request_random(input bit wild);
		int          k;
		int          j;
		int          idx;
		logic [31:0] a;
		k = $urandom_range(99);
		a = $urandom;
		if (k < 45 || (!wild && live_blocks.size() == 0)) begin
			issue_request(REQ_ALLOC, a, 1'b0, '0);
		end else if (k < 85) begin
			if (wild) begin
				idx = $urandom_range(BLOCKS - 1);
			end else begin
				j = $urandom_range(live_blocks.size() - 1);
				idx = live_blocks[j];
				live_blocks.delete(j);
			end
			issue_request(REQ_FREE, pool_base_q + idx * BLOCK_BYTES, 1'b0, '0);
		end else if (k < 90) begin
			issue_request(REQ_FREE, '0, 1'b0, '0);
		end else begin
			case ($urandom_range(3))
				0: a = $urandom;
				1: a = pool_base_q + (BLOCKS + $urandom_range(7)) * BLOCK_BYTES;
				2: a = pool_base_q + $urandom_range(BLOCKS - 1) * BLOCK_BYTES
					+ $urandom_range(1, BLOCK_BYTES - 1);
				default: a = pool_base_q - $urandom_range(1, 4) * BLOCK_BYTES;
			endcase
			issue_request(REQ_FREE, a, 1'b0, '0);
		end
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_pool_base(input logic [31:0] b);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= b;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		pool_base_q = b;
		base_writes++;
	endtask

	task automatic set_gaps(input int m);
		send_idle_pct = (m == 1) ? 83 : (m == 3) ? 34 : 0;
		recv_stall_pct = (m == 2) ? 83 : (m == 3) ? 34 : 0;
	endtask

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing pending: status %0d", status);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.st) begin
					$error("status expected %0d got %0d", want.st, status);
					mismatches++;
				end
				if (block_addr !== want.addr) begin
					$error("block_addr expected %h got %h", want.addr, block_addr);
					mismatches++;
				end
				if (used_count !== want.used) begin
					$error("used_count expected %0d got %0d", want.used, used_count);
					mismatches++;
				end
				if (peak_count !== want.peak) begin
					$error("peak_count expected %0d got %0d", want.peak, peak_count);
					mismatches++;
				end
				if (want.st <= ST_BAD)
					status_tally[want.st]++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("fixed_block_pool_allocator_top_tb NOT OK");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] b;
		for (int i = 0; i < BLOCKS; i++)
			link_next[i] = i + 1;
		list_head = 0;
		blocks_used = 0;
		blocks_peak = 0;
		foreach (status_tally[i])
			status_tally[i] = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_pool_base('0);
		set_gaps(3);
		walk_rows(0, LATE_ROW);

		for (int p = 0; p < 8; p++) begin
			wait_for_results();
			case (p)
				0: b = 32'h0000_0000;
				1: b = 32'hFFFF_FFFF;
				2: b = 32'hFFFF_FFE0;
				3: b = 32'h8000_0000;
				4, 5: b = $urandom;
				6: b = $urandom & ~32'h1F;
				default: b = 32'hFFFF_FF00;
			endcase
			write_pool_base(b);
			set_gaps(p % 4);
			for (int i = 0; i < 100; i++) begin
				// hold off until the pipe has drained
				if (i == 50)
					wait_for_results();
				request_random(1'b0);
			end
		end

		wait_for_results();
		write_pool_base('0);
		set_gaps(3);
		walk_rows(LATE_ROW, ROW_COUNT);
		for (int i = 0; i < 60; i++)
			request_random(1'b1);

		wait_for_results();
		repeat (10) @(posedge clk);
		$display("%0d requests over %0d pool_base settings with idle and stall patterns",
			requests_sent, base_writes);
		$display("results: %0d allocated, %0d empty, %0d freed, %0d null, %0d rejected",
			status_tally[ST_ALLOC], status_tally[ST_EMPTY], status_tally[ST_FREED],
			status_tally[ST_NULL], status_tally[ST_BAD]);
		if (mismatches == 0)
			$display("fixed_block_pool_allocator_top_tb OK");
		else
			$display("fixed_block_pool_allocator_top_tb NOT OK");
		$finish;
	end

endmodule

@@ fixed_block_pool_allocator_top.f @@
rtl/fbpa_pkg.sv
rtl/fbpa_ram.sv
rtl/fbpa_ctrl.sv
rtl/fbpa_dpath.sv
rtl/fixed_block_pool_allocator_top.sv
dv/fixed_block_pool_allocator_top_tb.sv
